/* rtl/bim_pkg.sv */
// bim_pkg: shared types and codes for the box IoU best-match block.
// No dependencies.
package bim_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam int ID_BITS   = 8;
  localparam int IOU_BITS  = 17;
  localparam int FRAC_BITS = 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_QA,
    S_RD,
    S_OV,
    S_MUL,
    S_UNI,
    S_XM,
    S_CMP,
    S_DIV,
    S_OUT
  } state_e;

endpackage

/* rtl/bim_front.sv */
// bim_front: input channel and two-entry item queue; decodes the op field.
// Depends on bim_pkg.
module bim_front #(
  parameter int CoordBits = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    op_i,
  input  logic [bim_pkg::ID_BITS-1:0]   box_id_i,
  input  logic [CoordBits-1:0]          x_min_i,
  input  logic [CoordBits-1:0]          y_min_i,
  input  logic [CoordBits-1:0]          x_max_i,
  input  logic [CoordBits-1:0]          y_max_i,
  output logic                          item_valid_o,
  input  logic                          item_ready_i,
  output bim_pkg::op_e                  item_op_o,
  output logic [bim_pkg::ID_BITS-1:0]   item_id_o,
  output logic [4*CoordBits-1:0]        item_box_o
);

  localparam int EW = 2 + bim_pkg::ID_BITS + 4 * CoordBits;

  logic [EW-1:0] fifo_q [2];
  logic          wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push, pop;
  logic [EW-1:0] rd_ent;

  assign in_ready_o   = (cnt_q != 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  assign rd_ent     = fifo_q[rd_ptr_q];
  assign item_op_o  = bim_pkg::op_e'(rd_ent[EW-1 -: 2]);
  assign item_id_o  = rd_ent[4*CoordBits +: bim_pkg::ID_BITS];
  assign item_box_o = rd_ent[4*CoordBits-1:0];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= {op_i, box_id_i, x_min_i, y_min_i, x_max_i, y_max_i};
    end
  end

endmodule

/* rtl/bim_back.sv */
// bim_back: box table, per-entry IoU scoring, restoring divider, result register.
// Depends on bim_pkg.
module bim_back #(
  parameter int TableEntries = 16,
  parameter int CoordBits    = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           item_valid_i,
  output logic                           item_ready_o,
  input  bim_pkg::op_e                   item_op_i,
  input  logic [bim_pkg::ID_BITS-1:0]    item_id_i,
  input  logic [4*CoordBits-1:0]         item_box_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     status_o,
  output logic [bim_pkg::ID_BITS-1:0]    match_id_o,
  output logic [bim_pkg::IOU_BITS-1:0]   match_iou_o
);

  localparam int C   = CoordBits;
  localparam int AW  = 2 * C;
  localparam int DW  = AW + 1;
  localparam int PW  = AW + DW;
  localparam int IW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CW  = $clog2(TableEntries + 1);
  localparam int EW  = bim_pkg::ID_BITS + 4 * C;
  localparam int QB  = bim_pkg::IOU_BITS;
  localparam logic [CW-1:0] FullCnt = CW'(TableEntries);
  localparam logic [4:0]    LastDiv = 5'(QB - 1);

  bim_pkg::state_e state_q, state_d;

  logic [EW-1:0] mem_q [TableEntries];
  logic [EW-1:0] rdata_q;

  logic [CW-1:0] count_q;
  logic [CW-1:0] idx_q;
  bim_pkg::op_e  op_q;
  logic [bim_pkg::ID_BITS-1:0] id_q;
  logic [C-1:0]  qx0_q, qy0_q, qx1_q, qy1_q;

  logic [AW-1:0] aq_q, inter_q, ar_q, best_n_q;
  logic [DW-1:0] uni_q, best_d_q;
  logic [C-1:0]  dx_q, dy_q, rw_q, rh_q;
  logic          ov_q, found_q;
  logic [PW-1:0] p1_q, p2_q;
  logic [bim_pkg::ID_BITS-1:0] best_id_q, eid_q;
  logic [1:0]    res_status_q;
  logic [DW:0]   rem_q, rem_sh;
  logic [QB-1:0] quo_q;
  logic [4:0]    dstep_q;

  logic          out_valid_q;
  logic [1:0]    status_q;
  logic [bim_pkg::ID_BITS-1:0] mid_q;
  logic [QB-1:0] miou_q;

  logic [C-1:0] ex0, ey0, ex1, ey1, xa, xb, ya, yb;
  logic         last_entry, out_free, take_item, load_out;

  assign ex0 = rdata_q[3*C +: C];
  assign ey0 = rdata_q[2*C +: C];
  assign ex1 = rdata_q[C +: C];
  assign ey1 = rdata_q[0 +: C];
  assign xa  = (qx0_q > ex0) ? qx0_q : ex0;
  assign xb  = (qx1_q < ex1) ? qx1_q : ex1;
  assign ya  = (qy0_q > ey0) ? qy0_q : ey0;
  assign yb  = (qy1_q < ey1) ? qy1_q : ey1;

  assign last_entry = (idx_q + CW'(1) == count_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign rem_sh     = (dstep_q == 5'd0) ? rem_q : {rem_q[DW-1:0], 1'b0};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bim_pkg::S_IDLE: if (item_valid_i) state_d = bim_pkg::S_DEC;
      bim_pkg::S_DEC: begin
        if (op_q == bim_pkg::OP_QUERY && count_q != '0) state_d = bim_pkg::S_QA;
        else state_d = bim_pkg::S_OUT;
      end
      bim_pkg::S_QA:  state_d = bim_pkg::S_RD;
      bim_pkg::S_RD:  state_d = bim_pkg::S_OV;
      bim_pkg::S_OV:  state_d = bim_pkg::S_MUL;
      bim_pkg::S_MUL: state_d = bim_pkg::S_UNI;
      bim_pkg::S_UNI: state_d = bim_pkg::S_XM;
      bim_pkg::S_XM:  state_d = bim_pkg::S_CMP;
      bim_pkg::S_CMP: begin
        if (!last_entry) state_d = bim_pkg::S_RD;
        else if (found_q || (ov_q && p1_q > p2_q)) state_d = bim_pkg::S_DIV;
        else state_d = bim_pkg::S_OUT;
      end
      bim_pkg::S_DIV: if (dstep_q == LastDiv) state_d = bim_pkg::S_OUT;
      bim_pkg::S_OUT: if (out_free) state_d = bim_pkg::S_IDLE;
      default: state_d = bim_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    take_item = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      bim_pkg::S_IDLE: take_item = item_valid_i;
      bim_pkg::S_OUT:  load_out  = out_free;
      default: ;
    endcase
  end

  assign item_ready_o = take_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bim_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == bim_pkg::S_DEC) begin
        if (op_q == bim_pkg::OP_CLEAR) count_q <= '0;
        else if (op_q == bim_pkg::OP_APPEND && count_q != FullCnt) count_q <= count_q + CW'(1);
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == bim_pkg::S_DEC && op_q == bim_pkg::OP_APPEND && count_q != FullCnt) begin
      mem_q[count_q[IW-1:0]] <= {id_q, qx0_q, qy0_q, qx1_q, qy1_q};
    end
    if (state_q == bim_pkg::S_RD) rdata_q <= mem_q[idx_q[IW-1:0]];
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (take_item) begin
      op_q  <= item_op_i;
      id_q  <= item_id_i;
      qx0_q <= item_box_i[3*C +: C];
      qy0_q <= item_box_i[2*C +: C];
      qx1_q <= item_box_i[C +: C];
      qy1_q <= item_box_i[0 +: C];
    end
    case (state_q)
      bim_pkg::S_DEC: begin
        best_n_q  <= '0;
        best_d_q  <= DW'(1);
        best_id_q <= '0;
        found_q   <= 1'b0;
        idx_q     <= '0;
        quo_q     <= '0;
        case (op_q)
          bim_pkg::OP_APPEND: res_status_q <= (count_q == FullCnt) ? bim_pkg::ST_FULL
                                                                   : bim_pkg::ST_OK;
          bim_pkg::OP_QUERY:  res_status_q <= bim_pkg::ST_NONE;
          default:            res_status_q <= bim_pkg::ST_OK;
        endcase
      end
      // query area; used for every entry, whether or not the query is well formed
      bim_pkg::S_QA: aq_q <= (qx1_q - qx0_q) * (qy1_q - qy0_q);
      bim_pkg::S_OV: begin
        ov_q  <= (xa < xb) && (ya < yb);
        dx_q  <= xb - xa;
        dy_q  <= yb - ya;
        rw_q  <= ex1 - ex0;
        rh_q  <= ey1 - ey0;
        eid_q <= rdata_q[EW-1 -: bim_pkg::ID_BITS];
      end
      bim_pkg::S_MUL: begin
        inter_q <= dx_q * dy_q;
        ar_q    <= rw_q * rh_q;
      end
      bim_pkg::S_UNI: uni_q <= {1'b0, aq_q} + {1'b0, ar_q} - {1'b0, inter_q};
      bim_pkg::S_XM: begin
        p1_q <= inter_q * best_d_q;
        p2_q <= best_n_q * uni_q;
      end
      bim_pkg::S_CMP: begin
        // strict compare keeps the earliest box on ties
        if (ov_q && p1_q > p2_q) begin
          best_n_q     <= inter_q;
          best_d_q     <= uni_q;
          best_id_q    <= eid_q;
          found_q      <= 1'b1;
          res_status_q <= bim_pkg::ST_OK;
          rem_q        <= {2'b00, inter_q};
        end else begin
          rem_q <= {2'b00, best_n_q};
        end
        idx_q   <= idx_q + CW'(1);
        dstep_q <= '0;
      end
      bim_pkg::S_DIV: begin
        if (rem_sh >= {1'b0, best_d_q}) begin
          rem_q <= rem_sh - {1'b0, best_d_q};
          quo_q <= {quo_q[QB-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[QB-2:0], 1'b0};
        end
        dstep_q <= dstep_q + 5'd1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_q <= res_status_q;
      mid_q    <= found_q ? best_id_q : '0;
      miou_q   <= found_q ? quo_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign match_id_o  = mid_q;
  assign match_iou_o = miou_q;

endmodule

/* rtl/box_iou_best_match.sv */
// box_iou_best_match: top level; front queue plus execution back end.
// Depends on bim_pkg, bim_front, bim_back.
//
// Usage: items arrive on the in_valid_i/in_ready_o channel (op, id, box);
// each gives exactly one result transfer on out_valid_o/out_ready_i.
// Op clear empties the table, op append stores a box (status full when the
// table holds TABLE_ENTRIES boxes), op query scores the box against every
// stored box and returns the id and Q1.16 IoU of the best one.
// A two-entry queue accepts items while the back end is busy.
// Clear, append and nop pass from decode straight to the output state.
// A query on a non-empty table first computes the query area; the back end
// then walks the table one entry at a time through a
// six-step scoring sequence (read, overlap, areas, union, cross products,
// compare), then a restoring divider makes one quotient bit per cycle.
// Without any overlap the divider is skipped.
// A query on an empty table skips the scoring and goes to the output state.
// Reset empties the table and the queue and drops any pending result.
// When the receiver stalls the result is held in the output register; the
// back end waits there, and the queue keeps taking up to two more items.
module box_iou_best_match #(
  parameter int TABLE_ENTRIES = 16,
  parameter int COORD_BITS    = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    op_i,
  input  logic [bim_pkg::ID_BITS-1:0]   box_id_i,
  input  logic [COORD_BITS-1:0]         x_min_i,
  input  logic [COORD_BITS-1:0]         y_min_i,
  input  logic [COORD_BITS-1:0]         x_max_i,
  input  logic [COORD_BITS-1:0]         y_max_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic [bim_pkg::ID_BITS-1:0]   match_id_o,
  output logic [bim_pkg::IOU_BITS-1:0]  match_iou_o
);

  logic                        item_valid, item_ready;
  bim_pkg::op_e                item_op;
  logic [bim_pkg::ID_BITS-1:0] item_id;
  logic [4*COORD_BITS-1:0]     item_box;

  bim_front #(
    .CoordBits(COORD_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .box_id_i,
    .x_min_i,
    .y_min_i,
    .x_max_i,
    .y_max_i,
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_op_o    (item_op),
    .item_id_o    (item_id),
    .item_box_o   (item_box)
  );

  bim_back #(
    .TableEntries (TABLE_ENTRIES),
    .CoordBits    (COORD_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_op_i    (item_op),
    .item_id_i    (item_id),
    .item_box_i   (item_box),
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .match_id_o,
    .match_iou_o
  );

endmodule
